@@ rtl/core/climb_budget_topk_heap_unit_macros.svh @@
// Assertion macros shared by the RTL of the climb budget heap unit.
// They expect i_clk and i_rst_n in the scope of the module that uses them.
`ifndef CLIMB_BUDGET_TOPK_HEAP_UNIT_MACROS_SVH
`define CLIMB_BUDGET_TOPK_HEAP_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CBTH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
`define CBTH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CBTH_ASSERT(label, prop, msg)
`define CBTH_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/cbth_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cbth_pkg;

    localparam int HEAP_DEPTH  = 64;
    localparam int HEIGHT_BITS = 20;

    localparam int HEIGHT_FIELD_W = 20;
    localparam int POS_W          = 20;
    localparam int BUDGET_W       = 30;
    localparam int FREE_W         = 7;
    localparam int PDATA_W        = 32;
    localparam int PADDR_W        = 3;

    // Heap fill count runs from 0 to HEAP_DEPTH inclusive.
    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int LIM_W  = (FREE_W > CNT_W) ? FREE_W : CNT_W;
    localparam int CHG_W  = (HEIGHT_BITS > BUDGET_W) ? HEIGHT_BITS : BUDGET_W;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Register select, taken from the word address bit of paddr.
    localparam logic REG_BUDGET = 1'b0;
    localparam logic REG_FREE   = 1'b1;

    typedef struct packed {
        logic [HEIGHT_FIELD_W-1:0] height;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] furthest_index;
        logic             blocked;
    } t_out_item;

    typedef struct packed {
        logic                   push;
        logic                   replace;
        logic [HEIGHT_BITS-1:0] value;
        logic [CNT_W-1:0]       count;
    } t_heap_cmd;

    typedef struct packed {
        logic                   busy;
        logic [HEIGHT_BITS-1:0] root;
    } t_heap_stat;

endpackage

`default_nettype wire

@@ rtl/core/cbth_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]                          o_rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                          o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ rtl/core/cbth_heap.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbth_heap (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cbth_pkg::t_heap_cmd   i_cmd,
    output cbth_pkg::t_heap_stat  o_stat
);
    import cbth_pkg::*;

    typedef enum logic [4:0] {
        H_IDLE   = 5'b00001,
        H_UP_RD  = 5'b00010,
        H_UP_CMP = 5'b00100,
        H_DN_RD  = 5'b01000,
        H_DN_CMP = 5'b10000
    } t_hstate;

    t_hstate                r_state, n_state;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_par, n_par;
    logic [CNT_W:0]         r_left, n_left;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [HEIGHT_BITS-1:0] r_val, n_val;
    logic [HEIGHT_BITS-1:0] r_root;

    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [HEIGHT_BITS-1:0] w_wdata;
    logic [ADDR_W-1:0]      w_raddr_a;
    logic [ADDR_W-1:0]      w_raddr_b;
    logic [HEIGHT_BITS-1:0] w_rdata_a;
    logic [HEIGHT_BITS-1:0] w_rdata_b;

    logic [CNT_W:0]         w_left;
    logic [CNT_W:0]         w_right;
    logic [CNT_W:0]         w_right_c;
    logic [CNT_W-1:0]       w_parent;
    logic                   w_take_l;
    logic                   w_take_r;
    logic [HEIGHT_BITS-1:0] w_min_val;

    cbth_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // Children of node i sit at 2i+1 and 2i+2, the parent at (i-1)/2.
    assign w_left    = {r_idx, 1'b1};
    assign w_right   = w_left + 1'b1;
    assign w_right_c = r_left + 1'b1;
    assign w_parent  = CNT_W'((r_idx - 1'b1) >> 1);

    assign w_take_l  = (w_rdata_a < r_val);
    assign w_min_val = w_take_l ? w_rdata_a : r_val;
    assign w_take_r  = (w_right_c < {1'b0, r_n}) && (w_rdata_b < w_min_val);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_par     = r_par;
        n_left    = r_left;
        n_n       = r_n;
        n_val     = r_val;
        w_we      = 1'b0;
        w_waddr   = r_idx[ADDR_W-1:0];
        w_wdata   = r_val;
        w_raddr_a = '0;
        w_raddr_b = '0;
        case (r_state)
            H_IDLE: begin
                if (i_cmd.push) begin
                    n_idx   = i_cmd.count;
                    n_val   = i_cmd.value;
                    n_state = H_UP_RD;
                end else if (i_cmd.replace) begin
                    n_idx   = '0;
                    n_n     = i_cmd.count;
                    n_val   = i_cmd.value;
                    n_state = H_DN_RD;
                end
            end
            H_UP_RD: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    w_raddr_a = w_parent[ADDR_W-1:0];
                    n_par     = w_parent;
                    n_state   = H_UP_CMP;
                end
            end
            H_UP_CMP: begin
                w_we = 1'b1;
                if (w_rdata_a <= r_val) begin
                    n_state = H_IDLE;
                end else begin
                    // Parent moves down into the hole and the climb goes on.
                    w_wdata = w_rdata_a;
                    n_idx   = r_par;
                    n_state = H_UP_RD;
                end
            end
            H_DN_RD: begin
                if (w_left >= {1'b0, r_n}) begin
                    w_we    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    w_raddr_a = w_left[ADDR_W-1:0];
                    w_raddr_b = w_right[ADDR_W-1:0];
                    n_left    = w_left;
                    n_state   = H_DN_CMP;
                end
            end
            H_DN_CMP: begin
                w_we = 1'b1;
                if (w_take_r) begin
                    w_wdata = w_rdata_b;
                    n_idx   = CNT_W'(w_right_c);
                    n_state = H_DN_RD;
                end else if (w_take_l) begin
                    w_wdata = w_rdata_a;
                    n_idx   = CNT_W'(r_left);
                    n_state = H_DN_RD;
                end else begin
                    n_state = H_IDLE;
                end
            end
            default: begin
                n_state = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_par  <= n_par;
        r_left <= n_left;
        r_n    <= n_n;
        r_val  <= n_val;
        // Keep a copy of the root so the top level can compare without a read.
        if (w_we && (w_waddr == '0)) begin
            r_root <= w_wdata;
        end
    end

    assign o_stat.busy = (r_state != H_IDLE);
    assign o_stat.root = r_root;

endmodule

`default_nettype wire

@@ rtl/core/climb_budget_topk_heap_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_in_item  (height, last)
// out      output     o_out_valid / i_out_stall o_out_item (furthest_index, blocked)
// cfg      input      APB psel/penable/pwrite   budget at 0x0, free_climbs at 0x4
//
// An item is registered in S_IDLE and evaluated in S_EVAL. A push climbs from the new
// leaf until its parent is no larger or it reaches the root; a replace of the minimum
// sinks from the root until no child is smaller or it ends on a node without children.
// The heap sequencer does a read, then a compare and write, for each level that a value
// climbs or sinks.
// Reset is synchronous; the RAM is not cleared. A stalled waiting result holds evaluation.

`include "climb_budget_topk_heap_unit_macros.svh"

module climb_budget_topk_heap_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  cbth_pkg::t_in_item                 i_in_item,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output cbth_pkg::t_out_item                o_out_item,
    input  logic                               i_out_stall,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbth_pkg::PADDR_W-1:0]       paddr,
    input  logic [cbth_pkg::PDATA_W-1:0]       pwdata,
    output logic [cbth_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import cbth_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    t_in_item               r_item, n_item;
    logic [BUDGET_W-1:0]    r_budget;
    logic [FREE_W-1:0]      r_free;
    logic [HEIGHT_BITS-1:0] r_prev, n_prev;
    logic                   r_have_prev, n_have_prev;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [BUDGET_W-1:0]    r_rem, n_rem;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_stopped, n_stopped;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    t_heap_cmd              h_cmd;
    t_heap_stat             h_stat;

    logic                   w_in_acc;
    logic                   w_cfg_wr;
    logic                   w_go;
    logic                   w_clear;
    logic [HEIGHT_BITS-1:0] w_h;
    logic [HEIGHT_BITS-1:0] w_rise;
    logic                   w_up;
    logic                   w_below_lim;
    logic                   w_root_lt;
    logic                   w_charged;
    logic [HEIGHT_BITS-1:0] w_charge;
    logic                   w_fail;
    logic [POS_W-1:0]       w_pos_inc;

    cbth_heap u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (h_cmd),
        .o_stat  (h_stat)
    );

    assign o_in_stall = (r_state != S_IDLE) || h_stat.busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_go       = !(r_out_valid && i_out_stall);

    assign w_h    = HEIGHT_BITS'(r_item.height);
    assign w_up   = (w_h > r_prev);
    assign w_rise = w_h - r_prev;

    // The free limit is free_climbs capped at the heap depth.
    assign w_below_lim = (LIM_W'(r_count) < LIM_W'(r_free))
                         && (r_count < CNT_W'(HEAP_DEPTH));
    assign w_root_lt   = (r_count != '0) && (h_stat.root < w_rise);
    assign w_charged   = w_up && !w_below_lim;
    assign w_charge    = w_root_lt ? h_stat.root : w_rise;
    assign w_fail      = w_charged && (CHG_W'(w_charge) > CHG_W'(r_rem));
    assign w_pos_inc   = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_count     = r_count;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_stopped   = r_stopped;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_clear     = 1'b0;
        h_cmd       = '0;
        h_cmd.value = w_rise;
        h_cmd.count = r_count;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item  = i_in_item;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_go) begin
                    n_state = S_IDLE;
                    if (r_stopped) begin
                        w_clear = r_item.last;
                    end else if (!r_have_prev) begin
                        n_rem       = r_budget;
                        n_count     = '0;
                        n_pos       = '0;
                        n_have_prev = 1'b1;
                        n_prev      = w_h;
                        if (r_item.last) begin
                            n_out_valid          = 1'b1;
                            n_out.furthest_index = '0;
                            n_out.blocked        = 1'b0;
                            w_clear              = 1'b1;
                        end
                    end else if (w_fail) begin
                        n_out_valid          = 1'b1;
                        n_out.furthest_index = r_pos;
                        n_out.blocked        = 1'b1;
                        if (r_item.last) begin
                            w_clear = 1'b1;
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end else begin
                        if (w_charged) begin
                            n_rem = r_rem - BUDGET_W'(w_charge);
                        end
                        n_prev = w_h;
                        n_pos  = w_pos_inc;
                        if (r_item.last) begin
                            n_out_valid          = 1'b1;
                            n_out.furthest_index = w_pos_inc;
                            n_out.blocked        = 1'b0;
                            w_clear              = 1'b1;
                        end else if (w_up && w_below_lim) begin
                            h_cmd.push = 1'b1;
                            n_count    = CNT_W'(r_count + 1'b1);
                        end else if (w_charged && w_root_lt) begin
                            h_cmd.replace = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_clear) begin
            n_prev      = '0;
            n_have_prev = 1'b0;
            n_count     = '0;
            n_pos       = '0;
            n_stopped   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_count     <= '0;
            r_rem       <= '0;
            r_pos       <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_pos       <= n_pos;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
            r_free   <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[PADDR_W-1])
                REG_BUDGET: r_budget <= pwdata[BUDGET_W-1:0];
                REG_FREE:   r_free   <= pwdata[FREE_W-1:0];
                default:    r_budget <= r_budget;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1])
            REG_BUDGET: prdata = PDATA_W'(r_budget);
            REG_FREE:   prdata = PDATA_W'(r_free);
            default:    prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `CBTH_ASSERT_IMP(a_no_cmd_while_busy, h_cmd.push || h_cmd.replace, !h_stat.busy,
        "heap command issued while the heap sequencer is busy")
    `CBTH_ASSERT_IMP(a_push_has_room, h_cmd.push, r_count < CNT_W'(HEAP_DEPTH),
        "heap push issued on a full heap")
    `CBTH_ASSERT_IMP(a_replace_nonempty, h_cmd.replace, r_count != '0,
        "heap replace issued on an empty heap")
    `CBTH_ASSERT(a_count_in_range, r_count <= CNT_W'(HEAP_DEPTH),
        "heap count above heap depth")

endmodule

`default_nettype wire
